// ===== hw/rtl/wtt0_pkg.sv =====
// Shared constants and controller/datapath interface types for the t0 finder.
`default_nettype none

package wtt0_pkg;

   // Default geometry and counter width
   localparam int WIRES_DEF       = 279;
   localparam int PLANES_DEF      = 8;
   localparam int BINS_DEF        = 300;
   localparam int SEARCH_BINS_DEF = 199;
   localparam int COUNT_BITS_DEF  = 32;

   // Noise ratio register reset value, about 0.05 in Q0.16
   localparam logic [15:0] RATIO_RESET = 16'd3277;

   // Only hits from this region are counted
   localparam logic [2:0] REGION_REC = 3'd3;

   // Package codes
   localparam logic [1:0] PKG_ONE = 2'd1;
   localparam logic [1:0] PKG_TWO = 2'd2;

   // Planes per package
   localparam logic [2:0] PLANE_FIRST = 3'd1;
   localparam logic [2:0] PLANE_LAST  = 3'd4;

   // Histogram start in ns and bin width
   localparam logic [13:0] BIN_START_NS = 14'd400;
   localparam logic [12:0] T0_OFFSET    = 13'd400;
   localparam logic [12:0] BIN_WIDTH_NS = 13'd3;

   // Divide by three: q = (d * RECIP3) >> RECIP3_SHIFT, exact for 12-bit d
   localparam logic [15:0] RECIP3       = 16'd43691;
   localparam int          RECIP3_SHIFT = 17;

   // Output saturation limit
   localparam logic [12:0] T0_MAX = 13'd1023;

   // Item kinds
   localparam logic KIND_HIT    = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   // Commands from controller to datapath
   typedef struct packed {
      logic clr_write;
      logic load;
      logic decode;
      logic base;
      logic hit_read;
      logic hit_write;
      logic scan_read;
      logic res_load;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic kind;
      logic hit_ok;
      logic addr_ok;
      logic scan_last;
      logic pipe_idle;
      logic clr_last;
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/wire_time_histogram_t0_finder_top.sv =====
// One item is in the block at a time; no result for a hit item.
// Hit item: after accept, decode, base address, read and write back before the next accept,
// or decode and base address only when the hit is dropped.
// Search item: one read per bin for min(SEARCH_BINS, BINS) bins, then a 3-stage
// peak/product/cutoff drain and the result load; a bad address skips the reads.
// Reset: zero all PLANES*WIRES*BINS counters, one per cycle (669600 at default size),
// with req_stall high; the noise ratio resets to 3277.
`default_nettype none

module wire_time_histogram_t0_finder_top #(
   parameter int WIRES       = wtt0_pkg::WIRES_DEF,
   parameter int PLANES      = wtt0_pkg::PLANES_DEF,
   parameter int BINS        = wtt0_pkg::BINS_DEF,
   parameter int SEARCH_BINS = wtt0_pkg::SEARCH_BINS_DEF,
   parameter int COUNT_BITS  = wtt0_pkg::COUNT_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic               req_kind,
   input  wire logic [2:0]         req_region,
   input  wire logic [1:0]         req_package_req,
   input  wire logic [2:0]         req_plane,
   input  wire logic [8:0]         req_wire_req,
   input  wire logic signed [12:0] req_drift_time,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [9:0]         rsp_t0_value,
   output      logic               rsp_found,
   input  wire logic               csr_wr_en,
   input  wire logic [15:0]        csr_wr_data
);

   wtt0_pkg::cmd_type    cmd;
   wtt0_pkg::status_type status;

   wtt0_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   wtt0_dp #(
      .WIRES       (WIRES),
      .PLANES      (PLANES),
      .BINS        (BINS),
      .SEARCH_BINS (SEARCH_BINS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_region      (req_region),
      .req_package_req (req_package_req),
      .req_plane       (req_plane),
      .req_wire_req    (req_wire_req),
      .req_drift_time  (req_drift_time),
      .rsp_t0_value    (rsp_t0_value),
      .rsp_found       (rsp_found),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/wtt0_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wtt0_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/wtt0_ctrl.sv =====
// Controller state machine: clearing pass, hit update and t0 search sequencing.
`default_nettype none

module wtt0_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      wtt0_pkg::cmd_type    cmd,
   input  wire wtt0_pkg::status_type status
);

   localparam logic [3:0] ST_CLR   = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_DEC   = 4'd2;
   localparam logic [3:0] ST_BASE  = 4'd3;
   localparam logic [3:0] ST_HRD   = 4'd4;
   localparam logic [3:0] ST_HWR   = 4'd5;
   localparam logic [3:0] ST_SCAN  = 4'd6;
   localparam logic [3:0] ST_DRAIN = 4'd7;
   localparam logic [3:0] ST_RESP  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            cmd.decode = 1'b1;
            state_in   = ST_BASE;
         end
         ST_BASE: begin
            cmd.base = 1'b1;
            if (status.kind == wtt0_pkg::KIND_HIT) begin
               state_in = status.hit_ok ? ST_HRD : ST_IDLE;
            end else begin
               state_in = status.addr_ok ? ST_SCAN : ST_DRAIN;
            end
         end
         ST_HRD: begin
            cmd.hit_read = 1'b1;
            state_in     = ST_HWR;
         end
         ST_HWR: begin
            cmd.hit_write = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_read = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.pipe_idle) begin
               cmd.res_load = 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/wtt0_dp.sv =====
// Datapath: address decode, binning, histogram store, peak and cutoff pipeline.
`default_nettype none

module wtt0_dp #(
   parameter int WIRES       = wtt0_pkg::WIRES_DEF,
   parameter int PLANES      = wtt0_pkg::PLANES_DEF,
   parameter int BINS        = wtt0_pkg::BINS_DEF,
   parameter int SEARCH_BINS = wtt0_pkg::SEARCH_BINS_DEF,
   parameter int COUNT_BITS  = wtt0_pkg::COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire wtt0_pkg::cmd_type     cmd,
   output      wtt0_pkg::status_type  status,
   input  wire logic                  req_kind,
   input  wire logic [2:0]            req_region,
   input  wire logic [1:0]            req_package_req,
   input  wire logic [2:0]            req_plane,
   input  wire logic [8:0]            req_wire_req,
   input  wire logic signed [12:0]    req_drift_time,
   output      logic [9:0]            rsp_t0_value,
   output      logic                  rsp_found,
   input  wire logic                  csr_wr_en,
   input  wire logic [15:0]           csr_wr_data
);

   localparam int SLOTS   = PLANES * WIRES;
   localparam int CELLS   = SLOTS * BINS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BIN_W   = $clog2(BINS);
   localparam int BINN_W  = BIN_W + 1;
   localparam int WIRE_W  = $clog2(WIRES + 1);
   localparam int SPROD_W = 3 + WIRE_W + 1;
   localparam int BPROD_W = SLOT_W + BINN_W;
   localparam int LIM     = (SEARCH_BINS < BINS) ? SEARCH_BINS : BINS;
   localparam int PROD_W  = COUNT_BITS + 16;

   // Captured item fields
   logic                kind_ff;
   logic [2:0]          region_ff;
   logic [1:0]          pkg_ff;
   logic [2:0]          plane_ff;
   logic [8:0]          wire_ff;
   logic signed [12:0]  time_ff;

   // Decode results
   logic [SLOT_W-1:0]   slot_ff;
   logic [BIN_W-1:0]    bin_ff;
   logic                hit_ok_ff;
   logic                addr_ok_ff;
   logic [ADDR_W-1:0]   base_ff;
   logic [BIN_W-1:0]    idx_ff;
   logic [15:0]         ratio_ff;
   logic [ADDR_W-1:0]   clr_idx_ff;

   // Scan pipeline
   logic                  rv1_ff, rv2_ff, rv3_ff;
   logic [BINN_W-1:0]     bin1_ff, bin2_ff, bin3_ff;
   logic [COUNT_BITS-1:0] cnt2_ff, cnt3_ff;
   logic [COUNT_BITS-1:0] peak_ff;
   logic [COUNT_BITS-1:0] peak_in;
   logic [PROD_W-1:0]     prod_ff;
   logic [BINN_W-1:0]     last_ff;

   // Decode combinational signals
   logic                  pkg_ok, plane_ok, wire_ok, pidx_ok, addr_ok;
   logic [2:0]            plane_m1;
   logic [2:0]            pidx;
   logic [8:0]            wire_m1;
   logic [SPROD_W-1:0]    slot_sum;
   logic signed [13:0]    dtime;
   logic [27:0]           div_prod;
   logic [10:0]           bin0;
   logic                  time_ok, bin_ok;
   logic [BPROD_W-1:0]    base_prod;

   // Memory signals
   logic [ADDR_W-1:0]     cell_addr;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [COUNT_BITS-1:0] mem_wdata;
   logic [COUNT_BITS-1:0] mem_rdata;
   logic [COUNT_BITS-1:0] cnt_inc;

   // Cutoff compare and result
   logic [PROD_W:0]       cut_lhs;
   logic [PROD_W:0]       cut_rhs;
   logic [12:0]           t0_full;

   // Capture item fields on accept
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         region_ff <= req_region;
         pkg_ff    <= req_package_req;
         plane_ff  <= req_plane;
         wire_ff   <= req_wire_req;
         time_ff   <= req_drift_time;
      end
   end

   // Map package, plane and wire to a slot; check the address
   always_comb begin
      pkg_ok   = (pkg_ff == wtt0_pkg::PKG_ONE) || (pkg_ff == wtt0_pkg::PKG_TWO);
      plane_ok = (plane_ff >= wtt0_pkg::PLANE_FIRST) && (plane_ff <= wtt0_pkg::PLANE_LAST);
      wire_ok  = (wire_ff != 9'd0) && ({2'b00, wire_ff} <= 11'(WIRES));
      plane_m1 = plane_ff - 3'd1;
      pidx     = {(pkg_ff == wtt0_pkg::PKG_TWO), plane_m1[1:0]};
      pidx_ok  = ({2'b00, pidx} < 5'(PLANES));
      addr_ok  = pkg_ok && plane_ok && wire_ok && pidx_ok;
      wire_m1  = wire_ff - 9'd1;
      slot_sum = SPROD_W'(pidx) * SPROD_W'(WIRES) + SPROD_W'(wire_m1);
   end

   // Negate time, subtract histogram start, divide by bin width
   always_comb begin
      dtime    = 14'sd0 - {time_ff[12], time_ff} - $signed(wtt0_pkg::BIN_START_NS);
      time_ok  = !dtime[13];
      div_prod = 28'(dtime[11:0]) * 28'(wtt0_pkg::RECIP3);
      bin0     = div_prod[wtt0_pkg::RECIP3_SHIFT +: 11];
      bin_ok   = (bin0 < 11'(BINS));
   end

   // Register decode results
   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         slot_ff    <= SLOT_W'(slot_sum);
         bin_ff     <= bin0[BIN_W-1:0];
         addr_ok_ff <= addr_ok;
         hit_ok_ff  <= addr_ok && time_ok && bin_ok && (region_ff == wtt0_pkg::REGION_REC);
      end
   end

   assign base_prod = BPROD_W'(slot_ff) * BPROD_W'(BINS);

   // Wire base address and cell index
   always_ff @(posedge clock) begin
      if (cmd.base) begin
         base_ff <= ADDR_W'(base_prod);
         idx_ff  <= (kind_ff == wtt0_pkg::KIND_SEARCH) ? '0 : bin_ff;
      end else if (cmd.scan_read) begin
         idx_ff  <= idx_ff + BIN_W'(1);
      end
   end

   // Noise ratio register
   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= wtt0_pkg::RATIO_RESET;
      end else if (csr_wr_en) begin
         ratio_ff <= csr_wr_data;
      end
   end

   // Clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clr_write) begin
         clr_idx_ff <= clr_idx_ff + ADDR_W'(1);
      end
   end

   // Memory access: clear, hit read-modify-write, scan reads
   assign cell_addr = base_ff + ADDR_W'(idx_ff);
   assign cnt_inc   = (mem_rdata == '1) ? mem_rdata : mem_rdata + COUNT_BITS'(1);
   assign mem_we    = cmd.clr_write || cmd.hit_write;
   assign mem_waddr = cmd.clr_write ? clr_idx_ff : cell_addr;
   assign mem_wdata = cmd.clr_write ? '0 : cnt_inc;

   wtt0_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (CELLS)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (cmd.hit_read || cmd.scan_read),
      .raddr (cell_addr),
      .rdata (mem_rdata)
   );

   // Scan pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         rv1_ff <= 1'b0;
         rv2_ff <= 1'b0;
         rv3_ff <= 1'b0;
      end else begin
         rv1_ff <= cmd.scan_read;
         rv2_ff <= rv1_ff;
         rv3_ff <= rv2_ff;
      end
   end

   assign peak_in = (mem_rdata > peak_ff) ? mem_rdata : peak_ff;

   // Advance peak, then product, then cutoff compare
   always_ff @(posedge clock) begin
      bin1_ff <= BINN_W'(idx_ff) + BINN_W'(1);
      bin2_ff <= bin1_ff;
      bin3_ff <= bin2_ff;
      cnt2_ff <= mem_rdata;
      cnt3_ff <= cnt2_ff;
      prod_ff <= PROD_W'(ratio_ff) * PROD_W'(peak_ff);
      if (cmd.base) begin
         peak_ff <= '0;
      end else if (rv1_ff) begin
         peak_ff <= peak_in;
      end
   end

   assign cut_lhs = {1'b0, cnt3_ff, 16'h0000};
   assign cut_rhs = {1'b0, prod_ff} + (PROD_W + 1)'(65536);

   // Keep the last bin above the cutoff
   always_ff @(posedge clock) begin
      if (cmd.base) begin
         last_ff <= '0;
      end else if (rv3_ff && (cut_lhs > cut_rhs)) begin
         last_ff <= bin3_ff;
      end
   end

   // Result register
   assign t0_full = 13'(last_ff) * wtt0_pkg::BIN_WIDTH_NS + wtt0_pkg::T0_OFFSET;

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         rsp_found    <= (last_ff != '0);
         if (last_ff == '0) begin
            rsp_t0_value <= '0;
         end else if (t0_full > wtt0_pkg::T0_MAX) begin
            rsp_t0_value <= wtt0_pkg::T0_MAX[9:0];
         end else begin
            rsp_t0_value <= t0_full[9:0];
         end
      end
   end

   // Status to controller
   always_comb begin
      status.kind      = kind_ff;
      status.hit_ok    = hit_ok_ff;
      status.addr_ok   = addr_ok_ff;
      status.scan_last = (idx_ff == BIN_W'(LIM - 1));
      status.pipe_idle = !rv1_ff && !rv2_ff && !rv3_ff;
      status.clr_last  = (clr_idx_ff == ADDR_W'(CELLS - 1));
   end

endmodule

`default_nettype wire
